@@ rtl/core/ekos_pkg.sv @@
// Shared types and constants for the exact-K odd subarray counter.
// Depends on nothing; ekos_window and the core module import it.
`timescale 1ns / 1ps

package ekos_pkg;

  // Field and register widths
  localparam int TGT_W          = 13;
  localparam int TOT_W          = 24;
  localparam int VALUE_W        = 32;
  localparam int MAX_LENGTH_DEF = 4096;

  localparam logic [TGT_W-1:0] TGT_RESET = 13'd1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_READ,
    ST_APPLY,
    ST_SUM,
    ST_FINISH
  } seq_state_t;

  // Per-window control from the sequencer
  typedef struct packed {
    logic clear;  // drop the run state
    logic load;   // store the new parity, count it
    logic apply;  // retire the leftmost element
    logic accum;  // add the window width to the total
  } win_ctl_t;

endpackage

@@ rtl/core/ekos_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ekos_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/ekos_window.sv @@
// One sliding window: its own parity memory copy, left pointer, odd count, total.
// Depends on ekos_pkg and ekos_ram.
`timescale 1ns / 1ps

module ekos_window
  import ekos_pkg::*;
#(
  parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  win_ctl_t                           ctl,
  input  logic                               parity,
  input  logic [$clog2(MAX_LENGTH+1)-1:0]    wr_index,
  output logic [$clog2(MAX_LENGTH+1)-1:0]    odds,
  output logic [$clog2(MAX_LENGTH+1)-1:0]    left,
  output logic [TOT_W-1:0]                   total
);

  localparam int CNT_W  = $clog2(MAX_LENGTH + 1);
  localparam int ADDR_W = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;

  logic              rd_parity;
  logic [CNT_W-1:0]  width;
  logic [TOT_W:0]    sum;

  // Parity copy: written at the write index, read at the left pointer
  ekos_ram #(
    .WIDTH (1),
    .DEPTH (MAX_LENGTH)
  ) u_store (
    .clk   (clk),
    .we    (ctl.load),
    .waddr (wr_index[ADDR_W-1:0]),
    .wdata (parity),
    .raddr (left[ADDR_W-1:0]),
    .rdata (rd_parity)
  );

  // Window width and saturating total
  assign width = wr_index - left;
  assign sum   = {1'b0, total} + (TOT_W+1)'(width);

  // Advance pointer, odd count and total
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      odds  <= '0;
      left  <= '0;
      total <= '0;
    end else begin
      if (ctl.load) begin
        odds <= odds + CNT_W'(parity);
      end else if (ctl.apply) begin
        odds <= odds - CNT_W'(rd_parity);
        left <= left + CNT_W'(1);
      end
      if (ctl.accum) begin
        total <= sum[TOT_W] ? {TOT_W{1'b1}} : sum[TOT_W-1:0];
      end
    end
  end

endmodule

@@ rtl/core/exact_k_odd_subarray_counter_core.sv @@
// Exact-K odd subarray counter: two sliding windows over memory-held parities.
// Each element goes through load, then read and apply per left-pointer step of the busier
// window (each step is a memory read then an update), then sum and finish.
// A new element is taken only once the last one has finished and the sequencer is idle.
// Reset (rst, synchronous) clears the run state and sets odd_target to 1; no clearing pass.
`timescale 1ns / 1ps

module exact_k_odd_subarray_counter_core
  import ekos_pkg::*;
#(
  parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // Input channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [VALUE_W-1:0] element_value,
  input  logic                      is_last,
  // Output channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [TOT_W-1:0]          subarray_count,
  // Configuration write channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [TGT_W-1:0]          cfg_data
);

  localparam int CNT_W = $clog2(MAX_LENGTH + 1);
  localparam int CMP_W = (CNT_W > TGT_W) ? CNT_W : TGT_W;

  seq_state_t       state, state_next;
  logic [TGT_W-1:0] odd_target;
  logic [CNT_W-1:0] write_index;
  logic             parity_q, last_q, store_ok;
  logic             need_a, need_b, need_a_q, need_b_q;
  logic             in_accept, out_free, emit;
  win_ctl_t         ctl_a, ctl_b;
  logic [CNT_W-1:0] odds_a, odds_b, left_a, left_b;
  logic [TOT_W-1:0] total_a, total_b;
  logic [CMP_W-1:0] odds_a_x, odds_b_x, target_x;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      odd_target <= TGT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      odd_target <= cfg_data;
    end
  end

  // Shrink conditions: window A holds at most K odds, window B at most K-1
  assign odds_a_x = CMP_W'(odds_a);
  assign odds_b_x = CMP_W'(odds_b);
  assign target_x = CMP_W'(odd_target);
  assign need_a   = (odds_a_x > target_x) && (left_a < write_index);
  assign need_b   = (odd_target != '0) && (odds_b_x >= target_x) &&
                    (left_b < write_index);

  // Sequencer state register and item registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      parity_q <= element_value[0];
      last_q   <= is_last;
      store_ok <= (write_index != CNT_W'(MAX_LENGTH));
    end
    if (state == ST_READ) begin
      need_a_q <= need_a;
      need_b_q <= need_b;
    end
  end

  // Next state and window controls
  always_comb begin
    state_next = state;
    ctl_a      = '0;
    ctl_b      = '0;
    emit       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        ctl_a.load = store_ok;
        ctl_b.load = store_ok;
        state_next = store_ok ? ST_READ : ST_FINISH;
      end
      ST_READ: begin
        // parity at each left pointer is read during this cycle
        state_next = (need_a || need_b) ? ST_APPLY : ST_SUM;
      end
      ST_APPLY: begin
        ctl_a.apply = need_a_q;
        ctl_b.apply = need_b_q;
        state_next  = ST_READ;
      end
      ST_SUM: begin
        ctl_a.accum = 1'b1;
        ctl_b.accum = (odd_target != '0);
        state_next  = ST_FINISH;
      end
      ST_FINISH: begin
        if (!last_q) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          emit       = 1'b1;
          ctl_a.clear = 1'b1;
          ctl_b.clear = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Element count of the current array
  always_ff @(posedge clk) begin
    if (rst || emit) begin
      write_index <= '0;
    end else if (ctl_a.load) begin
      write_index <= write_index + CNT_W'(1);
    end
  end

  ekos_window #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_win_a (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl_a),
    .parity   (parity_q),
    .wr_index (write_index),
    .odds     (odds_a),
    .left     (left_a),
    .total    (total_a)
  );

  ekos_window #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_win_b (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl_b),
    .parity   (parity_q),
    .wr_index (write_index),
    .odds     (odds_b),
    .left     (left_b),
    .total    (total_b)
  );

  // Output register: hold the beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      subarray_count <= (total_a >= total_b) ? (total_a - total_b) : '0;
    end
  end

  // Checks
  a_left_in_range: assert property (@(posedge clk) disable iff (rst)
    (left_a <= write_index) && (left_b <= write_index))
    else $error("left pointer passed the write index");

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    write_index <= CNT_W'(MAX_LENGTH))
    else $error("write index beyond capacity");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FINISH && last_q))
    else $error("result raised without a last element");

  a_apply_has_odds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_APPLY && need_a_q) |-> (odds_a != '0))
    else $error("window A shrinks with no odd element held");

  a_clear_after_emit: assert property (@(posedge clk) disable iff (rst)
    emit |=> (write_index == '0) && (left_a == '0) && (total_b == '0))
    else $error("run state not cleared after a result");

endmodule
